@@ src/rmsd_pkg.sv @@
// rmsd_pkg: transaction structs, fixed widths and sequencer states of the rmsd accumulator
// no dependencies; imported by rmsd_accumulator and rmsd_accumulator_tb

package rmsd_pkg;

   // coordinate and result widths
   localparam int COORD_W      = 20;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int SUM_W        = 56;
   localparam int ROOT_W       = SUM_W / 2;
   localparam int RMSD_W       = 21;
   localparam int PAIR_COUNT_W = 13;
   localparam int NUM_AXES     = 3;

   // one pair of atom positions
   typedef struct packed {
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] a_z;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] b_z;
      logic                      last;
   } req_type;

   // one finished set
   typedef struct packed {
      logic [RMSD_W-1:0]       rmsd;
      logic [PAIR_COUNT_W-1:0] pair_count;
      logic                    overflow;
   } rsp_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } state_type;

   // axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

@@ src/rmsd_accumulator.sv @@
// rmsd_accumulator: sums squared coordinate differences of atom pairs, then divides and roots
// depends on rmsd_pkg for transaction structs, widths and state encoding
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------
//  req      | in        | req_valid / req_ready  | rmsd_pkg::req_type (pair, last)
//  rsp      | out       | rsp_valid / rsp_ready  | rmsd_pkg::rsp_type (rmsd, count)
//
// an accumulated pair is accepted, then takes one multiply and one add per axis,
// all through a single squarer and a single saturating adder.
// a pair marked last then adds 56 restoring-division steps and 28 square-root steps on
// one shared compare-subtract unit, then loads the result register.
// a dropped pair (set already at MAX_ATOMS) keeps the sequencer idle unless marked last.
// req_ready is high only while the sequencer is idle; a full result register stalls the
// final load until rsp_ready. synchronous active-high reset clears all accumulated state.

module rmsd_accumulator #(
   parameter int MAX_ATOMS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rmsd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rmsd_pkg::rsp_type rsp_data
);

   import rmsd_pkg::*;

   localparam int CNT_W  = $clog2(MAX_ATOMS + 1);
   localparam int SUB_W  = (CNT_W + 1 > ROOT_W + 2) ? CNT_W + 1 : ROOT_W + 2;
   localparam int STEP_W = $clog2(SUM_W);

   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_ATOMS);
   localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

   // registers
   state_type         state_ff, state_in;
   req_type           item_ff, item_in;
   logic [1:0]        axis_ff, axis_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  pairs_ff, pairs_in;
   logic              dropped_ff, dropped_in;
   logic [SUB_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // control
   logic req_fire;
   logic set_full;
   logic load_rsp;

   // datapath signals
   logic signed [COORD_W-1:0] coord_a, coord_b;
   logic signed [DIFF_W-1:0]  diff;
   logic [DIFF_W-1:0]         mag;
   logic [SUM_W:0]            sum_wide;
   logic [CNT_W-1:0]          divisor;
   logic [SUB_W-1:0]          unit_rem, unit_operand, unit_diff;
   logic                      unit_ge;
   logic [CNT_W+PAIR_COUNT_W-1:0] count_ext;

   assign set_full = (pairs_ff >= CNT_MAX);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!set_full) begin
                  state_in = ST_MUL;
               end else if (req_data.last) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (axis_ff == AXIS_Z) begin
               state_in = item_ff.last ? ST_DIV : ST_IDLE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_DIV: begin
            if (step_ff == DIV_LAST) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (step_ff == SQRT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_DONE: begin
            load_rsp = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_fire = req_valid && req_ready;

   // coordinate select for the current axis
   always_comb begin
      case (axis_ff)
         AXIS_X: begin
            coord_a = item_ff.a_x;
            coord_b = item_ff.b_x;
         end
         AXIS_Y: begin
            coord_a = item_ff.a_y;
            coord_b = item_ff.b_y;
         end
         default: begin
            coord_a = item_ff.a_z;
            coord_b = item_ff.b_z;
         end
      endcase
   end

   // absolute difference, magnitude fits unsigned in DIFF_W bits
   assign diff = DIFF_W'(coord_a) - DIFF_W'(coord_b);
   assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

   // saturating accumulate of the registered square
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(prod_ff);

   // shared compare-subtract unit: division step or square-root step
   assign divisor = (pairs_ff == '0) ? CNT_W'(1) : pairs_ff;
   always_comb begin
      if (state_ff == ST_SQRT) begin
         unit_rem     = {rem_ff[SUB_W-3:0], sum_ff[SUM_W-1:SUM_W-2]};
         unit_operand = SUB_W'({root_ff, 2'b01});
      end else begin
         unit_rem     = {rem_ff[SUB_W-2:0], sum_ff[SUM_W-1]};
         unit_operand = SUB_W'(divisor);
      end
   end
   assign unit_ge   = (unit_rem >= unit_operand);
   assign unit_diff = unit_rem - unit_operand;

   // pair count folded to the output width
   assign count_ext = {{PAIR_COUNT_W{1'b0}}, pairs_ff};

   // register next values
   always_comb begin
      item_in      = item_ff;
      axis_in      = axis_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      pairs_in     = pairs_ff;
      dropped_in   = dropped_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // result register drains independently
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_in = req_data;
               axis_in = AXIS_X;
               step_in = '0;
               rem_in  = '0;
               if (!set_full) begin
                  pairs_in = pairs_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
         end
         ST_MUL: begin
            prod_in = PROD_W'(mag * mag);
         end
         ST_ADD: begin
            sum_in  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            axis_in = axis_ff + 2'd1;
            step_in = '0;
            rem_in  = '0;
         end
         ST_DIV: begin
            // quotient bits shift into the low end of the sum register
            rem_in  = unit_ge ? unit_diff : unit_rem;
            sum_in  = {sum_ff[SUM_W-2:0], unit_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == DIV_LAST) begin
               step_in = '0;
               rem_in  = '0;
               root_in = '0;
            end
         end
         ST_SQRT: begin
            // mean shifts out two bits per step
            rem_in  = unit_ge ? unit_diff : unit_rem;
            root_in = {root_ff[ROOT_W-2:0], unit_ge};
            sum_in  = {sum_ff[SUM_W-3:0], 2'b00};
            step_in = step_ff + STEP_W'(1);
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.rmsd       = (root_ff[ROOT_W-1:RMSD_W] != '0) ?
                                        {RMSD_W{1'b1}} : root_ff[RMSD_W-1:0];
               rsp_data_in.pair_count = count_ext[PAIR_COUNT_W-1:0];
               rsp_data_in.overflow   = dropped_ff;
               sum_in                 = '0;
               pairs_in               = '0;
               dropped_in             = 1'b0;
            end
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   // control and accumulated state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         pairs_ff     <= '0;
         dropped_ff   <= 1'b0;
         step_ff      <= '0;
         axis_ff      <= AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         pairs_ff     <= pairs_in;
         dropped_ff   <= dropped_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a result appears only out of the final load
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside final load");

   // the pair counter never passes the set limit
   a_pairs_bounded: assert property (@(posedge clock) disable iff (reset)
      pairs_ff <= CNT_MAX)
      else $error("pair counter beyond MAX_ATOMS");

   // a delivered set leaves the accumulator cleared
   a_clear_after_load: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (pairs_ff == '0 && !dropped_ff && sum_ff == '0 && state_ff == ST_IDLE))
      else $error("accumulator not cleared after result");

   // a pending result is not overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_data_ff))
      else $error("pending result changed");

endmodule

@@ bench/rmsd_accumulator_tb.sv @@
// rmsd_accumulator_tb: self-checking bench for the rmsd accumulator, directed table then random sets
// depends on rmsd_pkg (src/rmsd_pkg.sv) and rmsd_accumulator (src/rmsd_accumulator.sv)
// each accepted pair is folded into a local rmsd predictor; results are matched in order

module rmsd_accumulator_tb;
   import rmsd_pkg::*;

   localparam int SET_CAP       = 4096;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int END_WAIT      = 2000;
   localparam int END_TAIL      = 100;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic [SUM_W-1:0] SUM_FULL = '1;
   localparam logic [63:0] RMSD_TOP = (64'd1 << RMSD_W) - 64'd1;
   localparam longint SQ_LIMIT = 64'sd1 <<< 28;

   typedef struct {
      req_type item;
      bit      pinned;
      rsp_type want;
   } table_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // hand-typed result for the current directed row, if any
   bit      pinned_on = 1'b0;
   rsp_type pinned_rsp = '0;

   // predictor state: running set in Q.16
   logic [SUM_W-1:0] sum_q16 = '0;
   int               pairs_held = 0;
   bit               set_dropped = 1'b0;

   rsp_type       expected_q[$];
   table_row_type directed_rows[$];

   bit idle_on = 1'b1;
   int stall_left = 0;
   int cycle_count = 0;
   int pairs_sent = 0;
   int sets_closed = 0;
   int results_checked = 0;
   int mismatches = 0;

   rmsd_accumulator #(.MAX_ATOMS(SET_CAP)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 10 unit clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // squared difference of one axis, Q.16, saturating like the accumulator
   function automatic logic [SUM_W-1:0] diff_square(input logic signed [COORD_W-1:0] u,
                                                    input logic signed [COORD_W-1:0] v);
      longint d;
      longint m;
      d = longint'(u) - longint'(v);
      m = (d < 0) ? -d : d;
      if (m >= SQ_LIMIT) return SUM_FULL;
      return SUM_W'(m * m);
   endfunction

   function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? SUM_FULL : s[SUM_W-1:0];
   endfunction

   // floor square root, one bit at a time from the top
   function automatic logic [63:0] root_floor(input logic [SUM_W-1:0] n);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= {8'd0, n}) root = trial;
      end
      return root;
   endfunction

   // fold one pair into the running set; returns 1 with the finished set on last
   function automatic bit fold_pair(input req_type p, output rsp_type r);
      logic [SUM_W-1:0] t;
      logic [SUM_W-1:0] mean;
      logic [63:0]      root;
      r = '0;
      if (pairs_held < SET_CAP) begin
         t = sum_add(diff_square(p.a_x, p.b_x), diff_square(p.a_y, p.b_y));
         t = sum_add(t, diff_square(p.a_z, p.b_z));
         sum_q16 = sum_add(sum_q16, t);
         pairs_held++;
      end else begin
         set_dropped = 1'b1;
      end
      if (!p.last) return 1'b0;
      mean = sum_q16 / SUM_W'((pairs_held != 0) ? pairs_held : 1);
      root = root_floor(mean);
      r.rmsd = (root > RMSD_TOP) ? RMSD_TOP[RMSD_W-1:0] : root[RMSD_W-1:0];
      r.pair_count = pairs_held[PAIR_COUNT_W-1:0];
      r.overflow = set_dropped;
      sum_q16 = '0;
      pairs_held = 0;
      set_dropped = 1'b0;
      return 1'b1;
   endfunction

   function automatic rsp_type result_of(input int rmsd, input int count, input bit ovf);
      rsp_type r;
      r.rmsd = rmsd[RMSD_W-1:0];
      r.pair_count = count[PAIR_COUNT_W-1:0];
      r.overflow = ovf;
      return r;
   endfunction

   task automatic add_row(input logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz,
                          input bit lst, input bit pin, input rsp_type want);
      table_row_type row;
      row.item.a_x = ax;
      row.item.a_y = ay;
      row.item.a_z = az;
      row.item.b_x = bx;
      row.item.b_y = by;
      row.item.b_z = bz;
      row.item.last = lst;
      row.pinned = pin;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // random coordinate, weighted toward extremes and small values
   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return '0;
         3, 4: return COORD_W'($urandom_range(0, 4095) - 2048);
         default: return COORD_W'($urandom());
      endcase
   endfunction

   // mostly two close structures, sometimes unrelated points
   function automatic req_type make_pair(input bit lst);
      req_type p;
      p.a_x = pick_coord();
      p.a_y = pick_coord();
      p.a_z = pick_coord();
      if ($urandom_range(0, 2) != 0) begin
         p.b_x = p.a_x + COORD_W'($urandom_range(0, 1023) - 512);
         p.b_y = p.a_y + COORD_W'($urandom_range(0, 1023) - 512);
         p.b_z = p.a_z + COORD_W'($urandom_range(0, 1023) - 512);
      end else begin
         p.b_x = pick_coord();
         p.b_y = pick_coord();
         p.b_z = pick_coord();
      end
      p.last = lst;
      return p;
   endfunction

   // present one transaction from a falling edge; returns at the falling edge after accept
   task automatic drive_pair(input req_type item, input bit pin, input rsp_type want);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 11);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      pinned_on <= pin;
      pinned_rsp <= want;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_set(input int len);
      for (int k = 0; k < len; k++) begin
         drive_pair(make_pair(k == len - 1), 1'b0, '0);
      end
   endtask

   // hold off the sender until every set has reported
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic int pick_len();
      if ($urandom_range(0, 9) < 7) return $urandom_range(1, 8);
      if ($urandom_range(0, 1) != 0) return $urandom_range(9, 40);
      return 1;
   endfunction

   // result side back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left != 0 && idle_on) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 10);
      end else begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end
   end

   // check results in order, then fold accepted pairs into the predictor
   always @(posedge clock) begin : score
      rsp_type want;
      rsp_type folded;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result: rmsd %0d pair_count %0d overflow %0d",
                      rsp_data.rmsd, rsp_data.pair_count, rsp_data.overflow);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               results_checked++;
               if (rsp_data.rmsd !== want.rmsd) begin
                  $error("rmsd: expected %0d, got %0d", want.rmsd, rsp_data.rmsd);
                  mismatches++;
               end
               if (rsp_data.pair_count !== want.pair_count) begin
                  $error("pair_count: expected %0d, got %0d", want.pair_count,
                         rsp_data.pair_count);
                  mismatches++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $error("overflow: expected %0d, got %0d", want.overflow, rsp_data.overflow);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pairs_sent++;
            if (fold_pair(req_data, folded)) begin
               expected_q.push_back(pinned_on ? pinned_rsp : folded);
               sets_closed++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      int target;
      int waited;

      // directed table: typed results only where they are obvious
      add_row(0, 0, 0, 0, 0, 0, 1'b1, 1'b1, result_of(0, 1, 1'b0));
      add_row(COORD_MAX, 0, 0, COORD_MIN, 0, 0, 1'b1, 1'b1, result_of(1048575, 1, 1'b0));
      add_row(0, COORD_MIN, 0, 0, COORD_MAX, 0, 1'b1, 1'b1, result_of(1048575, 1, 1'b0));
      add_row(0, 0, COORD_MAX, 0, 0, COORD_MIN, 1'b1, 1'b1, result_of(1048575, 1, 1'b0));
      add_row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
              1'b1, 1'b0, '0);
      add_row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
              1'b1, 1'b1, result_of(0, 1, 1'b0));
      add_row(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
              1'b1, 1'b1, result_of(0, 1, 1'b0));
      // two pairs one angstrom apart in x
      add_row(256, 0, 0, 0, 0, 0, 1'b0, 1'b0, '0);
      add_row(-128, 0, 0, 128, 0, 0, 1'b1, 1'b1, result_of(256, 2, 1'b0));
      // one lsb off on each axis in turn
      add_row(1, 0, 0, 0, 0, 0, 1'b0, 1'b0, '0);
      add_row(0, 0, 0, 0, 1, 0, 1'b0, 1'b0, '0);
      add_row(0, 0, -1, 0, 0, 0, 1'b1, 1'b1, result_of(1, 3, 1'b0));
      // alternating bit patterns
      add_row(20'sh55555, 20'shAAAAA, 20'sh55555, 20'shAAAAA, 20'sh55555, 20'shAAAAA,
              1'b0, 1'b0, '0);
      add_row(20'shAAAAA, 20'sh55555, 20'shAAAAA, 20'sh55555, 20'shAAAAA, 20'sh55555,
              1'b1, 1'b0, '0);
      // mixed signs and sub-angstrom offsets
      add_row(-1000, 2000, -3000, 500, -700, 1234, 1'b0, 1'b0, '0);
      add_row(12345, -54321, 77, -9, 31000, -200000, 1'b0, 1'b0, '0);
      add_row(3, 5, 7, 2, 6, 9, 1'b1, 1'b0, '0);
      add_row(255, -255, 0, -1, 1, 0, 1'b1, 1'b0, '0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         drive_pair(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].want);
      end
      settle();

      // random sets, idling switched on and off per set
      while (pairs_sent < 570) begin
         idle_on <= ($urandom_range(0, 3) != 0);
         send_set(pick_len());
         if ($urandom_range(0, 14) == 0) settle();
      end
      idle_on <= 1'b0;
      settle();

      // closing stretch without idling on either side
      target = pairs_sent + 60;
      while (pairs_sent < target) send_set(pick_len());
      req_valid <= 1'b0;

      waited = 0;
      while (expected_q.size() != 0 && waited < END_WAIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (END_TAIL) @(posedge clock);
      if (expected_q.size() != 0) begin
         $error("%0d results never arrived", expected_q.size());
         mismatches++;
      end

      $display("%0d atom pairs sent in %0d sets, directed table then random set lengths",
               pairs_sent, sets_closed);
      $display("%0d results compared field by field, %0d mismatches", results_checked,
               mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/rmsd_pkg.sv
src/rmsd_accumulator.sv
bench/rmsd_accumulator_tb.sv
